// ===== rtl/vrg_pkg.sv =====
// Shared types and constants for the velocity ramp generator.
package vrg_pkg;

   localparam int unsigned VelWidth  = 24;
   localparam int unsigned StepWidth = 16;
   localparam int unsigned CmdWidth  = 2;
   localparam int unsigned IdxWidth  = 2;

   // Saturation limit of the target velocity, counts per second.
   localparam logic signed [VelWidth-1:0] VEL_LIMIT = 24'sd4194304;
   // Clamp of the per-tick velocity steps.
   localparam logic [StepWidth-1:0] STEP_LIMIT = 16'd65535;

   typedef enum logic [CmdWidth-1:0] {
      CMD_TICK  = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [IdxWidth-1:0] {
      REG_ACCEL_STEP      = 2'd0,
      REG_DECEL_STEP      = 2'd1,
      REG_TARGET_VELOCITY = 2'd2,
      REG_UNUSED          = 2'd3
   } reg_idx_type;

   // Configuration as seen by the ramp, already clamped and saturated.
   typedef struct packed {
      logic [StepWidth-1:0]        accel_step;
      logic [StepWidth-1:0]        decel_step;
      logic signed [VelWidth-1:0]  target_velocity;
   } cfg_type;

endpackage

// ===== rtl/vrg_if.sv =====
// Channel interfaces: command requests, ramp responses and register writes.
interface vrg_req_if;
   logic                                valid;
   logic                                ready;
   logic [vrg_pkg::CmdWidth-1:0]        command;
   logic signed [vrg_pkg::VelWidth-1:0] start_velocity;

   modport source (output valid, output command, output start_velocity, input ready);
   modport sink   (input valid, input command, input start_velocity, output ready);
endinterface

interface vrg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [vrg_pkg::VelWidth-1:0] velocity_reference;
   logic                                pending;

   modport source (output valid, output velocity_reference, output pending, input ready);
   modport sink   (input valid, input velocity_reference, input pending, output ready);
endinterface

interface vrg_csr_if;
   logic                                valid;
   logic                                ready;
   logic [vrg_pkg::IdxWidth-1:0]        index;
   logic [vrg_pkg::VelWidth-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/vrg_csr.sv =====
// Configuration registers with step clamping and target saturation.
module vrg_csr #(
   parameter logic signed [vrg_pkg::VelWidth-1:0] VEL_LIMIT  = vrg_pkg::VEL_LIMIT,
   parameter logic [vrg_pkg::StepWidth-1:0]       STEP_LIMIT = vrg_pkg::STEP_LIMIT
) (
   input  logic              clock,
   input  logic              reset,
   vrg_csr_if.sink           csr_bus,
   output vrg_pkg::cfg_type  cfg
);

   logic [vrg_pkg::StepWidth-1:0]       accel_ff;
   logic [vrg_pkg::StepWidth-1:0]       decel_ff;
   logic signed [vrg_pkg::VelWidth-1:0] target_ff;

   // Writes are always taken
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff  <= '0;
         decel_ff  <= '0;
         target_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (vrg_pkg::reg_idx_type'(csr_bus.index))
            vrg_pkg::REG_ACCEL_STEP:      accel_ff  <= csr_bus.data[vrg_pkg::StepWidth-1:0];
            vrg_pkg::REG_DECEL_STEP:      decel_ff  <= csr_bus.data[vrg_pkg::StepWidth-1:0];
            vrg_pkg::REG_TARGET_VELOCITY: target_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Clamp steps and saturate target on the way out
   always_comb begin
      cfg.accel_step = (accel_ff > STEP_LIMIT) ? STEP_LIMIT : accel_ff;
      cfg.decel_step = (decel_ff > STEP_LIMIT) ? STEP_LIMIT : decel_ff;
      if (target_ff > VEL_LIMIT) begin
         cfg.target_velocity = VEL_LIMIT;
      end else if (target_ff < -VEL_LIMIT) begin
         cfg.target_velocity = -VEL_LIMIT;
      end else begin
         cfg.target_velocity = target_ff;
      end
   end

endmodule

// ===== rtl/vrg_core.sv =====
// Ramp datapath: input register, ramp state update and result register.
module vrg_core (
   input  logic              clock,
   input  logic              reset,
   input  vrg_pkg::cfg_type  cfg,
   vrg_req_if.sink           req_bus,
   vrg_rsp_if.source         rsp_bus
);

   localparam int unsigned ExtWidth = vrg_pkg::VelWidth + 2;

   // Input stage
   logic                                s1_valid_ff;
   vrg_pkg::cmd_type                    s1_cmd_ff;
   logic signed [vrg_pkg::VelWidth-1:0] s1_start_ff;

   // Ramp state
   logic signed [vrg_pkg::VelWidth-1:0] ref_ff, ref_in;
   logic                                pend_ff, pend_in;

   // Result stage
   logic                                out_valid_ff;
   logic signed [vrg_pkg::VelWidth-1:0] out_vel_ff;
   logic                                out_pend_ff;

   logic                                advance;
   logic signed [ExtWidth-1:0]          v_ext, tgt_ext, step_ext, sum;
   logic signed [vrg_pkg::VelWidth-1:0] ramp_vel;
   logic                                slow_pos, slow_neg, dir_up;

   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         s1_cmd_ff   <= vrg_pkg::cmd_type'(req_bus.command);
         s1_start_ff <= req_bus.start_velocity;
      end
   end

   // One tick of the ramp: pick step and direction, then clamp at target
   always_comb begin
      v_ext   = {{2{ref_ff[vrg_pkg::VelWidth-1]}}, ref_ff};
      tgt_ext = {{2{cfg.target_velocity[vrg_pkg::VelWidth-1]}}, cfg.target_velocity};
      slow_pos = !cfg.target_velocity[vrg_pkg::VelWidth-1] && (ref_ff > cfg.target_velocity);
      slow_neg = (cfg.target_velocity <= 0) && (ref_ff < cfg.target_velocity);
      dir_up   = slow_neg || (!slow_pos && (cfg.target_velocity > 0));
      if (slow_pos || slow_neg) begin
         step_ext = {{(ExtWidth-vrg_pkg::StepWidth){1'b0}}, cfg.decel_step};
      end else begin
         step_ext = {{(ExtWidth-vrg_pkg::StepWidth){1'b0}}, cfg.accel_step};
      end
      sum = dir_up ? (v_ext + step_ext) : (v_ext - step_ext);
      // Landing on the target also covers a reference already at target
      if (dir_up ? (sum > tgt_ext) : (sum < tgt_ext)) begin
         ramp_vel = cfg.target_velocity;
      end else begin
         ramp_vel = sum[vrg_pkg::VelWidth-1:0];
      end
   end

   // Next state by command
   always_comb begin
      ref_in  = ref_ff;
      pend_in = pend_ff;
      case (s1_cmd_ff)
         vrg_pkg::CMD_TICK:  ref_in = ramp_vel;
         vrg_pkg::CMD_LOAD: begin
            ref_in  = s1_start_ff;
            pend_in = 1'b0;
         end
         vrg_pkg::CMD_CLEAR: begin
            ref_in  = '0;
            pend_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff  <= '0;
         pend_ff <= 1'b1;
      end else if (advance) begin
         ref_ff  <= ref_in;
         pend_ff <= pend_in;
      end
   end

   // Result register; a new item enters only when it is empty or its result is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_vel_ff  <= ref_in;
         out_pend_ff <= pend_in;
      end
   end

   assign rsp_bus.valid              = out_valid_ff;
   assign rsp_bus.velocity_reference = out_vel_ff;
   assign rsp_bus.pending            = out_pend_ff;

endmodule

// ===== rtl/velocity_ramp_generator_top.sv =====
// Velocity ramp generator: top level.
// Each request transfer carries a command (tick, load, clear) and a start
// velocity, and yields exactly one response transfer with the reference
// velocity and pending flag after that command. A request passes through the
// input register and then the result register; one request is taken every
// cycle while the response side keeps up. The single 26-bit add with its
// clamp against the saturated target sets the cycle time. Registers are
// written over the csr channel; the user must write them only while no
// request is in flight, as the block itself does not enforce this.
module velocity_ramp_generator_top #(
   parameter logic signed [vrg_pkg::VelWidth-1:0] VEL_LIMIT  = vrg_pkg::VEL_LIMIT,
   parameter logic [vrg_pkg::StepWidth-1:0]       STEP_LIMIT = vrg_pkg::STEP_LIMIT
) (
   input  logic        clock,
   input  logic        reset,
   vrg_req_if.sink     req_bus,
   vrg_rsp_if.source   rsp_bus,
   vrg_csr_if.sink     csr_bus
);

   vrg_pkg::cfg_type cfg;

   vrg_csr #(
      .VEL_LIMIT  (VEL_LIMIT),
      .STEP_LIMIT (STEP_LIMIT)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   vrg_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule
